[rtl/core/led_strip_mode_sequencer_top_assert.svh]
// Assertion macros shared by the LED strip mode sequencer RTL.
`ifndef LED_STRIP_MODE_SEQUENCER_TOP_ASSERT_SVH
`define LED_STRIP_MODE_SEQUENCER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and ignored while reset is asserted.
`define LSMS_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lsms: same-cycle check failed");
// Next-cycle implication, sampled on clk and ignored while reset is asserted.
`define LSMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lsms: next-cycle check failed");
`else
`define LSMS_ASSERT_IMPLIES(lbl, ante, cons)
`define LSMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/lsms_pkg.sv]
// Shared types, constants and color tables of the LED strip mode sequencer.
package lsms_pkg;

	// Strip geometry.
	localparam int unsigned PIXEL_COUNT = 4;
	localparam int unsigned IDX_W = 6;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

	// Field widths.
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned AUTO_W = 4;
	localparam int unsigned RB_W = 3;

	// Table sizes, as last legal entry.
	localparam logic [AUTO_W-1:0] AUTO_LAST = 4'd8;
	localparam logic [RB_W-1:0] RB_LAST = 3'd6;

	// Configuration port.
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_PERIOD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RB_PERIOD = 3'd6;

	// Pattern mode codes; the fourth code is never stored.
	localparam logic [1:0] MODE_AUTO = 2'd0;
	localparam logic [1:0] MODE_RAINBOW = 2'd1;
	localparam logic [1:0] MODE_STATIC = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// How the pixels of one frame get their color.
	typedef enum logic {
		KIND_SOLID,
		KIND_RAINBOW
	} frame_kind_t;

	// Frame descriptor handed from the decision logic to the pixel emitter.
	typedef struct packed {
		frame_kind_t kind;
		logic [COLOR_W-1:0] color;
		logic [RB_W-1:0] rb_start;
	} frame_desc_t;

	// Auto cycle colors, white and black at the end.
	function automatic logic [COLOR_W-1:0] auto_color(input logic [AUTO_W-1:0] step);
		logic [COLOR_W-1:0] c;
		case (step)
			4'd0: c = 24'hFF0000;
			4'd1: c = 24'hFF4500;
			4'd2: c = 24'hFFFF00;
			4'd3: c = 24'h00FF00;
			4'd4: c = 24'h0000FF;
			4'd5: c = 24'h4B0082;
			4'd6: c = 24'h9400D3;
			4'd7: c = 24'hFFFFFF;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

	// Rainbow chase colors.
	function automatic logic [COLOR_W-1:0] rainbow_color(input logic [RB_W-1:0] step);
		logic [COLOR_W-1:0] c;
		case (step)
			3'd0: c = 24'hFF0000;
			3'd1: c = 24'hFFA500;
			3'd2: c = 24'hFFFF00;
			3'd3: c = 24'h00FF00;
			3'd4: c = 24'h0000FF;
			3'd5: c = 24'h4B0082;
			3'd6: c = 24'h9400D3;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/lsms_if.sv]
// Valid/ready stream interfaces for polling passes and pixel results.
interface lsms_pass_if;
	logic valid;
	logic ready;
	logic [lsms_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, output now_ms, input ready);
	modport sink (input valid, input now_ms, output ready);
endinterface

interface lsms_pixel_if;
	logic valid;
	logic ready;
	logic [lsms_pkg::IDX_W-1:0] pixel_index;
	logic [lsms_pkg::COLOR_W-1:0] pixel_color;
	logic frame_last;

	modport source (output valid, output pixel_index, output pixel_color,
		output frame_last, input ready);
	modport sink (input valid, input pixel_index, input pixel_color,
		input frame_last, output ready);
endinterface

[rtl/core/led_strip_mode_sequencer_top.sv]
// Top level of the LED strip mode sequencer.
//
//   Channel    Direction  Handshake         Payload
//   pass       sink       valid / ready     now_ms
//   pixel      source     valid / ready     pixel_index, pixel_color, frame_last
//   cfg        write      cfg_we            cfg_index, cfg_data
//
// A pass is decided in the cycle it is accepted; a frame of PIXEL_COUNT pixels
// then leaves the output register one pixel per cycle unless pixel.ready stalls it.
// The frame descriptor slot paces the passes: while it holds a frame, the next pass
// is accepted in the cycle the final pixel of that frame enters the output register;
// a pass without a frame leaves the slot free.
// A stall on pixel.ready holds the output register and backs up into pass.ready.
// Reset restores the configuration defaults and clears the pattern state and every valid flag.
module led_strip_mode_sequencer_top (
	input  logic clk,
	input  logic arst_n,
	lsms_pass_if.sink pass,
	lsms_pixel_if.source pixel,
	input  logic cfg_we,
	input  logic [lsms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsms_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic free;
	logic accept;
	logic emit;
	lsms_pkg::frame_desc_t desc;

	// A pass transaction completes whenever the descriptor slot can take a frame.
	assign pass.ready = free;
	assign accept = pass.valid && free;

	lsms_decide u_decide (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.now_ms(pass.now_ms),
		.emit(emit),
		.desc(desc)
	);

	lsms_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept && emit),
		.desc(desc),
		.free(free),
		.pixel(pixel)
	);

endmodule

[rtl/core/lsms_decide.sv]
// Configuration registers, pattern state and the per-pass frame decision.
module lsms_decide (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lsms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsms_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic accept,
	input  logic [lsms_pkg::TIME_W-1:0] now_ms,
	output logic emit,
	output lsms_pkg::frame_desc_t desc
);

	logic enable_q;
	logic [1:0] mode_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [lsms_pkg::PERIOD_W-1:0] auto_period_q;
	logic [lsms_pkg::PERIOD_W-1:0] rb_period_q;

	logic [lsms_pkg::AUTO_W-1:0] auto_step_q;
	logic [lsms_pkg::RB_W-1:0] rb_step_q;
	logic [lsms_pkg::TIME_W-1:0] last_update_q;
	logic [lsms_pkg::COLOR_W-1:0] shown_q;
	logic shown_valid_q;

	logic [lsms_pkg::TIME_W-1:0] elapsed;
	logic auto_due;
	logic rb_due;
	logic [lsms_pkg::COLOR_W-1:0] custom;
	logic static_due;
	logic step_auto;
	logic step_rb;
	logic step_static;

	// Elapsed time modulo 2^32 and the three pattern triggers.
	assign elapsed = now_ms - last_update_q;
	assign auto_due = elapsed > {{(lsms_pkg::TIME_W - lsms_pkg::PERIOD_W){1'b0}}, auto_period_q};
	assign rb_due = elapsed > {{(lsms_pkg::TIME_W - lsms_pkg::PERIOD_W){1'b0}}, rb_period_q};
	assign custom = {red_q, green_q, blue_q};
	assign static_due = !shown_valid_q || (custom != shown_q);

	// Frame decision for the pass at the input port.
	always_comb begin
		emit = 1'b0;
		desc.kind = lsms_pkg::KIND_SOLID;
		desc.color = '0;
		desc.rb_start = rb_step_q;
		step_auto = 1'b0;
		step_rb = 1'b0;
		step_static = 1'b0;
		if (!enable_q) begin
			emit = 1'b1;
		end else begin
			case (mode_q)
				lsms_pkg::MODE_AUTO: begin
					emit = auto_due;
					step_auto = auto_due;
					desc.color = lsms_pkg::auto_color(auto_step_q);
				end
				lsms_pkg::MODE_RAINBOW: begin
					emit = rb_due;
					step_rb = rb_due;
					desc.kind = lsms_pkg::KIND_RAINBOW;
				end
				lsms_pkg::MODE_STATIC: begin
					emit = static_due;
					step_static = static_due;
					desc.color = custom;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// Configuration writes; a mode write with the unused code is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q <= lsms_pkg::MODE_AUTO;
			red_q <= 8'hFF;
			green_q <= 8'h00;
			blue_q <= 8'h00;
			auto_period_q <= 16'd2000;
			rb_period_q <= 16'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				lsms_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				lsms_pkg::REG_MODE: begin
					if (cfg_data[1:0] != lsms_pkg::MODE_UNUSED) begin
						mode_q <= cfg_data[1:0];
					end
				end
				lsms_pkg::REG_RED: red_q <= cfg_data[7:0];
				lsms_pkg::REG_GREEN: green_q <= cfg_data[7:0];
				lsms_pkg::REG_BLUE: blue_q <= cfg_data[7:0];
				lsms_pkg::REG_AUTO_PERIOD: auto_period_q <= cfg_data;
				lsms_pkg::REG_RB_PERIOD: rb_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pattern state: steps and timestamp cleared by a mode write with a used code, advanced by an accepted pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_step_q <= '0;
			rb_step_q <= '0;
			last_update_q <= '0;
			shown_q <= '0;
			shown_valid_q <= 1'b0;
		end else if (cfg_we && (cfg_index == lsms_pkg::REG_MODE)
				&& (cfg_data[1:0] != lsms_pkg::MODE_UNUSED)) begin
			auto_step_q <= '0;
			rb_step_q <= '0;
			last_update_q <= '0;
		end else if (accept) begin
			if (step_auto) begin
				auto_step_q <= (auto_step_q == lsms_pkg::AUTO_LAST) ? '0 : auto_step_q + 1'b1;
				last_update_q <= now_ms;
			end
			if (step_rb) begin
				rb_step_q <= (rb_step_q == lsms_pkg::RB_LAST) ? '0 : rb_step_q + 1'b1;
				last_update_q <= now_ms;
			end
			if (step_static) begin
				shown_q <= custom;
				shown_valid_q <= 1'b1;
			end
		end
	end

	`include "led_strip_mode_sequencer_top_assert.svh"

	// A static frame records the custom color as shown unless a mode write comes in the same cycle.
	`LSMS_ASSERT_NEXT(a_static_recorded, accept && step_static && !cfg_we, shown_valid_q && (shown_q == $past(custom)))
	// Step counters never leave their table ranges.
	`LSMS_ASSERT_IMPLIES(a_steps_in_range, 1'b1, (auto_step_q <= lsms_pkg::AUTO_LAST) && (rb_step_q <= lsms_pkg::RB_LAST))
	// A disabled strip emits on every pass.
	`LSMS_ASSERT_IMPLIES(a_blank_emits, !enable_q, emit && (desc.kind == lsms_pkg::KIND_SOLID))

endmodule

[rtl/core/lsms_emit.sv]
// Frame descriptor holder and pixel serializer with a registered output stage.
module lsms_emit (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  lsms_pkg::frame_desc_t desc,
	output logic free,
	lsms_pixel_if.source pixel
);

	logic desc_v_q;
	lsms_pkg::frame_desc_t desc_q;
	logic [lsms_pkg::RB_W-1:0] rb_idx_q;
	logic [lsms_pkg::IDX_W-1:0] pix_cnt_q;

	logic out_v_q;
	logic [lsms_pkg::IDX_W-1:0] idx_q;
	logic [lsms_pkg::COLOR_W-1:0] color_q;
	logic last_q;

	logic adv;
	logic take;
	logic is_last;
	logic [lsms_pkg::COLOR_W-1:0] pix_color;

	// The output register moves when empty or taken; the descriptor frees on its last pixel.
	assign adv = !out_v_q || pixel.ready;
	assign take = desc_v_q && adv;
	assign is_last = (pix_cnt_q == lsms_pkg::LAST_IDX);
	assign free = !desc_v_q || (take && is_last);
	assign pix_color = (desc_q.kind == lsms_pkg::KIND_RAINBOW)
		? lsms_pkg::rainbow_color(rb_idx_q) : desc_q.color;

	// Descriptor valid and rainbow index; a new frame loaded on the final
	// pixel of the current one takes over the slot in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_v_q <= 1'b0;
			rb_idx_q <= '0;
		end else if (load) begin
			desc_v_q <= 1'b1;
			rb_idx_q <= desc.rb_start;
		end else if (take) begin
			rb_idx_q <= (rb_idx_q == lsms_pkg::RB_LAST) ? '0 : rb_idx_q + 1'b1;
			if (is_last) begin
				desc_v_q <= 1'b0;
			end
		end
	end

	// Pixel counter within the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
		end else if (take) begin
			pix_cnt_q <= is_last ? '0 : pix_cnt_q + 1'b1;
		end
	end

	// Descriptor payload.
	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= desc_v_q;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			idx_q <= pix_cnt_q;
			color_q <= pix_color;
			last_q <= is_last;
		end
	end

	assign pixel.valid = out_v_q;
	assign pixel.pixel_index = idx_q;
	assign pixel.pixel_color = color_q;
	assign pixel.frame_last = last_q;

	`include "led_strip_mode_sequencer_top_assert.svh"

	// A new frame is only loaded into a free descriptor slot.
	`LSMS_ASSERT_IMPLIES(a_load_when_free, load, free)
	// The last flag marks exactly the final pixel of a frame.
	`LSMS_ASSERT_IMPLIES(a_last_matches_index, out_v_q, last_q == (idx_q == lsms_pkg::LAST_IDX))
	// A frame stays held until its final pixel has been issued.
	`LSMS_ASSERT_NEXT(a_frame_held, take && !is_last, desc_v_q)
	// The rainbow index stays inside its table.
	`LSMS_ASSERT_IMPLIES(a_rb_in_range, desc_v_q, rb_idx_q <= lsms_pkg::RB_LAST)

endmodule

[sim/led_strip_mode_sequencer_top_tb.sv]
// Self-checking testbench for the LED strip mode sequencer top level.
`timescale 1ns / 100ps

module led_strip_mode_sequencer_top_tb;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_PASSES = 30;
	localparam int CYCLE_LEN = 9;
	localparam int CHASE_LEN = 7;

	// Index past the last register; writes to it must change nothing.
	localparam logic [lsms_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// Color palettes, entry 0 in the low bits.
	localparam logic [CYCLE_LEN*lsms_pkg::COLOR_W-1:0] CYCLE_PALETTE = {
		24'h000000, 24'hFFFFFF, 24'h9400D3, 24'h4B0082, 24'h0000FF,
		24'h00FF00, 24'hFFFF00, 24'hFF4500, 24'hFF0000};
	localparam logic [CHASE_LEN*lsms_pkg::COLOR_W-1:0] CHASE_PALETTE = {
		24'h9400D3, 24'h4B0082, 24'h0000FF, 24'h00FF00,
		24'hFFFF00, 24'hFFA500, 24'hFF0000};

	typedef struct packed {
		logic [lsms_pkg::IDX_W-1:0] pix_idx;
		logic [lsms_pkg::COLOR_W-1:0] pix_color;
		logic pix_last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lsms_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lsms_pkg::CFG_DATA_W-1:0] cfg_data;

	lsms_pass_if pass_ch ();
	lsms_pixel_if pix_ch ();

	led_strip_mode_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pass(pass_ch),
		.pixel(pix_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the registers.
	logic sh_enable;
	logic [1:0] sh_mode;
	logic [7:0] sh_red;
	logic [7:0] sh_green;
	logic [7:0] sh_blue;
	logic [lsms_pkg::PERIOD_W-1:0] sh_auto_per;
	logic [lsms_pkg::PERIOD_W-1:0] sh_rb_per;

	// Predicted pattern state.
	logic [lsms_pkg::AUTO_W-1:0] auto_pos;
	logic [lsms_pkg::RB_W-1:0] chase_pos;
	logic [lsms_pkg::TIME_W-1:0] last_step_ms;
	logic [lsms_pkg::COLOR_W-1:0] held_color;
	logic held_valid;

	pixel_t pending_pixels[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_model();
		sh_enable = 1'b0;
		sh_mode = lsms_pkg::MODE_AUTO;
		sh_red = 8'd255;
		sh_green = 8'd0;
		sh_blue = 8'd0;
		sh_auto_per = 16'd2000;
		sh_rb_per = 16'd50;
		auto_pos = '0;
		chase_pos = '0;
		last_step_ms = '0;
		held_color = '0;
		held_valid = 1'b0;
	endfunction

	// Mirror of one register write; values are masked to the register width.
	function automatic void apply_reg(input logic [lsms_pkg::CFG_IDX_W-1:0] idx,
			input logic [lsms_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			lsms_pkg::REG_ENABLE: sh_enable = data[0];
			lsms_pkg::REG_MODE: begin
				if (data[1:0] != lsms_pkg::MODE_UNUSED) begin
					sh_mode = data[1:0];
					auto_pos = '0;
					chase_pos = '0;
					last_step_ms = '0;
				end
			end
			lsms_pkg::REG_RED: sh_red = data[7:0];
			lsms_pkg::REG_GREEN: sh_green = data[7:0];
			lsms_pkg::REG_BLUE: sh_blue = data[7:0];
			lsms_pkg::REG_AUTO_PERIOD: sh_auto_per = data;
			lsms_pkg::REG_RB_PERIOD: sh_rb_per = data;
			default: ;
		endcase
	endfunction

	function automatic void push_pixel(input int pos,
			input logic [lsms_pkg::COLOR_W-1:0] color);
		pixel_t px;
		px.pix_idx = lsms_pkg::IDX_W'(pos);
		px.pix_color = color;
		px.pix_last = (pos == lsms_pkg::PIXEL_COUNT - 1);
		pending_pixels.push_back(px);
	endfunction

	function automatic void push_solid(input logic [lsms_pkg::COLOR_W-1:0] color);
		for (int p = 0; p < lsms_pkg::PIXEL_COUNT; p++)
			push_pixel(p, color);
	endfunction

	// Expected frame, if any, of one accepted pass; updates the pattern state.
	function automatic void predict_frame(input logic [lsms_pkg::TIME_W-1:0] stamp);
		logic [lsms_pkg::TIME_W-1:0] elapsed;
		logic [lsms_pkg::COLOR_W-1:0] custom;
		int slot;
		elapsed = stamp - last_step_ms;
		custom = {sh_red, sh_green, sh_blue};
		if (!sh_enable) begin
			push_solid('0);
		end else begin
			case (sh_mode)
				lsms_pkg::MODE_AUTO: begin
					if (elapsed > lsms_pkg::TIME_W'(sh_auto_per)) begin
						slot = int'(auto_pos);
						push_solid(CYCLE_PALETTE[slot * lsms_pkg::COLOR_W +: lsms_pkg::COLOR_W]);
						auto_pos = (slot == CYCLE_LEN - 1) ? '0 : auto_pos + 1'b1;
						last_step_ms = stamp;
					end
				end
				lsms_pkg::MODE_RAINBOW: begin
					if (elapsed > lsms_pkg::TIME_W'(sh_rb_per)) begin
						for (int p = 0; p < lsms_pkg::PIXEL_COUNT; p++) begin
							slot = (int'(chase_pos) + p) % CHASE_LEN;
							push_pixel(p,
								CHASE_PALETTE[slot * lsms_pkg::COLOR_W +: lsms_pkg::COLOR_W]);
						end
						chase_pos = (int'(chase_pos) == CHASE_LEN - 1) ? '0 : chase_pos + 1'b1;
						last_step_ms = stamp;
					end
				end
				lsms_pkg::MODE_STATIC: begin
					if (!held_valid || custom != held_color) begin
						push_solid(custom);
						held_color = custom;
						held_valid = 1'b1;
					end
				end
				default: ;
			endcase
		end
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Sends one pass after a random gap and predicts its frame on acceptance.
	task automatic send_pass(input logic [lsms_pkg::TIME_W-1:0] stamp);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		repeat (gap) @(negedge clk) pass_ch.valid = 1'b0;
		@(negedge clk);
		pass_ch.valid = 1'b1;
		pass_ch.now_ms = stamp;
		do @(posedge clk); while (!(pass_ch.valid && pass_ch.ready));
		predict_frame(stamp);
	endtask

	// Drops valid, waits for every expected pixel, then lets the block go idle.
	task automatic settle();
		@(negedge clk) pass_ch.valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [lsms_pkg::CFG_IDX_W-1:0] idx,
			input logic [lsms_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		apply_reg(idx, data);
		@(negedge clk) cfg_we = 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [lsms_pkg::PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return lsms_pkg::PERIOD_W'($urandom_range(1, 20));
			3: return lsms_pkg::PERIOD_W'($urandom_range(20, 200));
			default: return lsms_pkg::PERIOD_W'($urandom);
		endcase
	endfunction

	// Time step between passes, clustered around the active period.
	function automatic logic [lsms_pkg::TIME_W-1:0] next_delta();
		logic [lsms_pkg::TIME_W-1:0] per;
		per = (sh_mode == lsms_pkg::MODE_RAINBOW) ? lsms_pkg::TIME_W'(sh_rb_per)
			: lsms_pkg::TIME_W'(sh_auto_per);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			2: return per;
			3: return per + 1;
			default: return lsms_pkg::TIME_W'($urandom_range(0, 2 * per + 2));
		endcase
	endfunction

	// A disabled strip blanks every pass, at both ends of the time range.
	task automatic test_disabled_blank();
		send_pass('0);
		send_pass('1);
	endtask

	// Auto cycle through all nine colors with a zero period, across the time wrap.
	task automatic test_auto_cycle();
		settle();
		write_reg(lsms_pkg::REG_ENABLE, 16'd1);
		write_reg(lsms_pkg::REG_AUTO_PERIOD, 16'd0);
		write_reg(lsms_pkg::REG_MODE, 16'(lsms_pkg::MODE_AUTO));
		send_pass(32'hFFFF_FFFE);
		send_pass(32'hFFFF_FFFE);
		for (int t = 0; t < 8; t++)
			send_pass(lsms_pkg::TIME_W'(t));
	endtask

	// Rainbow steps happen only once the period is exceeded.
	task automatic test_rainbow_chase();
		settle();
		write_reg(lsms_pkg::REG_RB_PERIOD, 16'd50);
		write_reg(lsms_pkg::REG_MODE, 16'(lsms_pkg::MODE_RAINBOW));
		send_pass(32'd50);
		send_pass(32'd51);
		send_pass(32'd101);
		send_pass(32'd102);
	endtask

	// Static color shows on change only; blanking keeps the shown color.
	task automatic test_static_color();
		settle();
		write_reg(lsms_pkg::REG_MODE, 16'(lsms_pkg::MODE_STATIC));
		send_pass(32'd7);
		send_pass(32'd8);
		settle();
		write_reg(lsms_pkg::REG_GREEN, 16'hFF);
		write_reg(lsms_pkg::REG_BLUE, 16'hFF);
		send_pass(32'd9);
		settle();
		write_reg(lsms_pkg::REG_ENABLE, 16'd0);
		send_pass(32'd10);
		settle();
		write_reg(lsms_pkg::REG_ENABLE, 16'd1);
		send_pass(32'd11);
		settle();
		// The unused mode code and a write past the last register are ignored.
		write_reg(lsms_pkg::REG_MODE, 16'(lsms_pkg::MODE_UNUSED));
		write_reg(REG_NONE, 16'hFFFF);
		write_reg(lsms_pkg::REG_RED, 16'h0);
		write_reg(lsms_pkg::REG_GREEN, 16'h0);
		write_reg(lsms_pkg::REG_BLUE, 16'h0);
		send_pass(32'd12);
	endtask

	// The receiver holds off while passes keep coming, so the input backs up.
	task automatic test_output_backpressure();
		settle();
		write_reg(lsms_pkg::REG_ENABLE, 16'd0);
		no_idle = 1'b1;
		hold_req = 1'b1;
		for (int n = 0; n < 20; n++)
			send_pass($urandom);
		no_idle = 1'b0;
	endtask

	// Random phases of register settings, each followed by a run of passes.
	task automatic test_random_phases();
		logic [lsms_pkg::TIME_W-1:0] stamp;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			no_idle = ($urandom_range(0, 4) == 0);
			write_reg(lsms_pkg::REG_ENABLE, {15'($urandom), 1'($urandom_range(0, 5) != 0)});
			if ($urandom_range(0, 3) != 0)
				write_reg(lsms_pkg::REG_MODE, 16'($urandom));
			if ($urandom_range(0, 1) != 0)
				write_reg(lsms_pkg::REG_RED, {8'($urandom), pick_byte()});
			if ($urandom_range(0, 1) != 0)
				write_reg(lsms_pkg::REG_GREEN, {8'($urandom), pick_byte()});
			if ($urandom_range(0, 1) != 0)
				write_reg(lsms_pkg::REG_BLUE, {8'($urandom), pick_byte()});
			write_reg(lsms_pkg::REG_AUTO_PERIOD, pick_period());
			write_reg(lsms_pkg::REG_RB_PERIOD, pick_period());
			if ($urandom_range(0, 3) == 0)
				stamp = 32'hFFFF_FFFF - lsms_pkg::TIME_W'($urandom_range(0, 500));
			else
				stamp = $urandom;
			for (int n = 0; n < PHASE_PASSES; n++) begin
				stamp = stamp + next_delta();
				send_pass(stamp);
			end
		end
		no_idle = 1'b0;
	endtask

	// Pixel receiver: a random wait per transaction, or one long hold on request.
	initial begin
		pix_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk) pix_ch.ready = 1'b0;
			end else begin
				repeat (no_idle ? 0 : $urandom_range(0, 8)) @(negedge clk) pix_ch.ready = 1'b0;
			end
			@(negedge clk) pix_ch.ready = 1'b1;
			do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
		end
	end

	// Compare each pixel transaction with the oldest expected pixel.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				report($sformatf("unexpected pixel %0d color %06h",
					pix_ch.pixel_index, pix_ch.pixel_color));
			end else begin
				want = pending_pixels.pop_front();
				if (pix_ch.pixel_index !== want.pix_idx)
					report($sformatf("pixel_index %0d, expected %0d",
						pix_ch.pixel_index, want.pix_idx));
				if (pix_ch.pixel_color !== want.pix_color)
					report($sformatf("pixel_color %06h, expected %06h on pixel %0d",
						pix_ch.pixel_color, want.pix_color, want.pix_idx));
				if (pix_ch.frame_last !== want.pix_last)
					report($sformatf("frame_last %b, expected %b on pixel %0d",
						pix_ch.frame_last, want.pix_last, want.pix_idx));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel and no register write.
	always @(posedge clk) begin
		if (!arst_n || (pass_ch.valid && pass_ch.ready) || (pix_ch.valid && pix_ch.ready)
				|| cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("led_strip_mode_sequencer_top test failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		reset_model();
		arst_n = 1'b0;
		pass_ch.valid = 1'b0;
		pass_ch.now_ms = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_disabled_blank();
		test_auto_cycle();
		test_rainbow_chase();
		test_static_color();
		test_output_backpressure();
		test_random_phases();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("led_strip_mode_sequencer_top test passed");
		else
			$display("led_strip_mode_sequencer_top test failed");
		$finish;
	end

endmodule
